### design/gpb_pkg.sv
// ---------------------------------------------------------------------------
// gpb_pkg
// Shared register indexes for the ground-plane back-projection unit.
// ---------------------------------------------------------------------------
package gpb_pkg;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FOCAL_X      = 3'd0,
      REG_FOCAL_Y      = 3'd1,
      REG_CENTER_X     = 3'd2,
      REG_CENTER_Y     = 3'd3,
      REG_NORMAL_X     = 3'd4,
      REG_NORMAL_Y     = 3'd5,
      REG_NORMAL_Z     = 3'd6,
      REG_PLANE_OFFSET = 3'd7
   } csr_reg_type;

endpackage

### design/gpb_front.sv
// ---------------------------------------------------------------------------
// gpb_front
// Ray, plane dot product and dividends, in six register stages.
// ---------------------------------------------------------------------------
module gpb_front
   import gpb_pkg::*;
#(
   parameter int W = 32,
   parameter int F = 16,
   localparam int DEN_W = 3*W+4,
   localparam int NUM_W = 3*W+3+F
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic signed [W-1:0]       box_left,
   input  logic signed [W-1:0]       box_top,
   input  logic [W-2:0]              box_width,
   input  logic [W-2:0]              box_height,
   input  logic [W-2:0]              focal_x,
   input  logic [W-2:0]              focal_y,
   input  logic signed [W-1:0]       center_x,
   input  logic signed [W-1:0]       center_y,
   input  logic signed [W-1:0]       normal_x,
   input  logic signed [W-1:0]       normal_y,
   input  logic signed [W-1:0]       normal_z,
   input  logic signed [W-1:0]       plane_offset,
   output logic                      out_vld,
   output logic [DEN_W-1:0]          den_mag,
   output logic                      den_neg,
   output logic [2:0][NUM_W-1:0]     num_mag,
   output logic [2:0]                num_neg,
   output logic                      err
);
   localparam int DU_W = W+2;
   localparam int AB_W = 2*W+2;
   localparam int L    = W+1;
   localparam int NP_W = 3*W+3;

   logic [5:0] vld_ff;

   logic signed [DU_W-1:0] du_ff, du_in, dv_ff, dv_in;
   logic signed [AB_W-1:0] abc_ff [3];
   logic signed [AB_W-1:0] abc_in [3];
   logic signed [W-1:0]    nrm [3];
   logic signed [W:0]      negoff;
   logic signed [DEN_W-1:0] dlo_ff [3], dhi_ff [3], dlo_in [3], dhi_in [3];
   logic signed [NP_W-1:0]  nlo_ff [3], nhi_ff [3], nlo_in [3], nhi_in [3];
   logic signed [DEN_W-1:0] dterm_ff [3], dterm_in [3];
   logic signed [NUM_W-1:0] num_ff [3], num_in [3];
   logic signed [DEN_W-1:0] den5_ff, den5_in;
   logic [2:0][NUM_W-1:0]   mag5_ff, mag5_in, mag6_ff;
   logic [2:0]              neg5_ff, neg6_ff;
   logic [DEN_W-1:0]        den_mag_ff, den_mag_in;
   logic                    den_neg_ff, err_ff, err_in;
   logic signed [NP_W-1:0]  nsum [3];

   assign nrm[0] = normal_x;
   assign nrm[1] = normal_y;
   assign nrm[2] = normal_z;
   assign negoff = (W+1)'(0) - (W+1)'(plane_offset);

   // Bottom-centre point relative to the principal point
   always_comb begin
      du_in = DU_W'(box_left) + DU_W'(box_width >> 1) - DU_W'(center_x);
      dv_in = DU_W'(box_top) + DU_W'(box_height) - DU_W'(center_y);
   end

   // Ray scaled by both focal lengths
   always_comb begin
      abc_in[0] = AB_W'(du_ff) * AB_W'($signed({1'b0, focal_y}));
      abc_in[1] = AB_W'(dv_ff) * AB_W'($signed({1'b0, focal_x}));
      abc_in[2] = AB_W'($signed({1'b0, focal_x})) * AB_W'($signed({1'b0, focal_y}));
   end

   // Partial products on the low and high halves of each ray term
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dlo_in[j] = DEN_W'(nrm[j]) * DEN_W'($signed({1'b0, abc_ff[j][L-1:0]}));
         dhi_in[j] = DEN_W'(nrm[j]) * DEN_W'($signed(abc_ff[j][AB_W-1:L]));
         nlo_in[j] = NP_W'(negoff) * NP_W'($signed({1'b0, abc_ff[j][L-1:0]}));
         nhi_in[j] = NP_W'(negoff) * NP_W'($signed(abc_ff[j][AB_W-1:L]));
      end
   end

   // Recombine halves and scale the dividends by the fraction
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dterm_in[j] = dlo_ff[j] + (dhi_ff[j] <<< L);
         nsum[j]     = nlo_ff[j] + (nhi_ff[j] <<< L);
         num_in[j]   = NUM_W'(nsum[j]) <<< F;
      end
   end

   // Plane dot product and dividend magnitudes
   always_comb begin
      den5_in = dterm_ff[0] + dterm_ff[1] + dterm_ff[2];
      for (int j = 0; j < 3; j++) begin
         mag5_in[j] = num_ff[j][NUM_W-1] ? NUM_W'(-num_ff[j]) : NUM_W'(num_ff[j]);
      end
   end

   // Divisor magnitude and degenerate-ray check
   always_comb begin
      den_mag_in = den5_ff[DEN_W-1] ? DEN_W'(-den5_ff) : DEN_W'(den5_ff);
      err_in     = (den5_ff == '0) || (focal_x == '0) || (focal_y == '0);
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_vld};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         du_ff <= du_in;
         dv_ff <= dv_in;
         for (int j = 0; j < 3; j++) begin
            abc_ff[j]   <= abc_in[j];
            dlo_ff[j]   <= dlo_in[j];
            dhi_ff[j]   <= dhi_in[j];
            nlo_ff[j]   <= nlo_in[j];
            nhi_ff[j]   <= nhi_in[j];
            dterm_ff[j] <= dterm_in[j];
            num_ff[j]   <= num_in[j];
            neg5_ff[j]  <= num_ff[j][NUM_W-1];
         end
         den5_ff    <= den5_in;
         mag5_ff    <= mag5_in;
         mag6_ff    <= mag5_ff;
         neg6_ff    <= neg5_ff;
         den_mag_ff <= den_mag_in;
         den_neg_ff <= den5_ff[DEN_W-1];
         err_ff     <= err_in;
      end
   end

   assign out_vld = vld_ff[5];
   assign den_mag = den_mag_ff;
   assign den_neg = den_neg_ff;
   assign num_mag = mag6_ff;
   assign num_neg = neg6_ff;
   assign err     = err_ff;

endmodule

### design/gpb_div.sv
// ---------------------------------------------------------------------------
// gpb_div
// Pipelined restoring divider, one quotient bit per stage, with range check.
// ---------------------------------------------------------------------------
module gpb_div
   import gpb_pkg::*;
#(
   parameter int W = 32,
   parameter int F = 16,
   localparam int DEN_W = 3*W+4,
   localparam int NUM_W = 3*W+3+F
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic [NUM_W-1:0]     num_mag,
   input  logic                 num_neg,
   input  logic [DEN_W-1:0]     den_mag,
   input  logic                 den_neg,
   input  logic                 err_in,
   output logic                 out_vld,
   output logic signed [W-1:0]  quot,
   output logic                 err
);
   localparam int CW = (NUM_W > DEN_W+W) ? NUM_W : DEN_W+W;

   logic          vld_ff [W+1];
   logic [CW-1:0] rem_ff [W+1];
   logic [CW-1:0] den_ff [W+1];
   logic [W-1:0]  q_ff   [W+1];
   logic          neg_ff [W+1];
   logic          err_ff [W+1];
   logic [W-1:0]  q_fin;
   logic          fit;

   // Entry: reject any quotient of more than W magnitude bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= CW'(num_mag);
         den_ff[0] <= CW'(den_mag);
         q_ff[0]   <= '0;
         neg_ff[0] <= num_neg ^ den_neg;
         err_ff[0] <= err_in || (CW'(num_mag) >= (CW'(den_mag) << W));
      end
   end

   // One trial subtraction per stage, most significant bit first
   for (genvar k = 1; k <= W; k++) begin : g_step
      logic [CW:0]   trial;
      logic [CW-1:0] rem_in;
      logic [W-1:0]  q_in;

      always_comb begin
         trial  = {1'b0, rem_ff[k-1]} - {1'b0, den_ff[k-1] << (W-k)};
         rem_in = trial[CW] ? rem_ff[k-1] : trial[CW-1:0];
         q_in   = q_ff[k-1];
         q_in[W-k] = ~trial[CW];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_in;
            neg_ff[k] <= neg_ff[k-1];
            err_ff[k] <= err_ff[k-1];
         end
      end
   end

   // Apply the sign and check the signed range
   always_comb begin
      q_fin = q_ff[W];
      if (neg_ff[W]) begin
         fit = ~q_fin[W-1] || (q_fin[W-2:0] == '0);
      end else begin
         fit = ~q_fin[W-1];
      end
   end

   assign out_vld = vld_ff[W];
   assign err     = err_ff[W] || ~fit;
   assign quot    = neg_ff[W] ? $signed(W'(-q_fin)) : $signed(q_fin);

endmodule

### design/ground_plane_backprojection_unit.sv
// ---------------------------------------------------------------------------
// ground_plane_backprojection_unit
// Back-projects a box's bottom-centre point onto a ground plane.
// ---------------------------------------------------------------------------
// Usage: each req_ transfer carries one detection box; each rsp_ transfer
// carries the matching 3D point and an error flag, in the same order.
// Camera and plane settings are written through csr_ while the unit is idle;
// the user must keep to this, as the unit does not enforce it. A box passes
// through six stages of ray, dot product and dividend, then one range-check
// stage and one stage per quotient bit in each of three parallel dividers.
// Throughput is one box per cycle when not stalled; per-bit stages set depth.
// Reset clears every valid bit and loads focal lengths 1.0, normal (0,1,0),
// all else zero; no item is in flight afterwards.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module ground_plane_backprojection_unit
   import gpb_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_WIDTH-1:0]       csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // box_left, box_top, box_width, box_height, zero pad
   input  logic [((4*DATA_WIDTH-2+7)/8)*8-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // pos_x, pos_y, pos_z, no_intersection, zero pad
   output logic [((3*DATA_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);
   localparam int W     = DATA_WIDTH;
   localparam int IN_W  = ((4*W-2+7)/8)*8;
   localparam int OUT_W = ((3*W+1+7)/8)*8;
   localparam int DEN_W = 3*W+4;
   localparam int NUM_W = 3*W+3+FRAC_BITS;

   logic [W-2:0]        focal_x_ff, focal_y_ff;
   logic signed [W-1:0] center_x_ff, center_y_ff;
   logic signed [W-1:0] normal_x_ff, normal_y_ff, normal_z_ff, offset_ff;

   logic                  en;
   logic                  f_vld, f_den_neg, f_err;
   logic [DEN_W-1:0]      f_den_mag;
   logic [2:0][NUM_W-1:0] f_num_mag;
   logic [2:0]            f_num_neg;
   logic [2:0]            d_vld, d_err;
   logic signed [W-1:0]   d_quot [3];
   logic                  any_err;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= (W-1)'(64'd1 << FRAC_BITS);
         focal_y_ff  <= (W-1)'(64'd1 << FRAC_BITS);
         center_x_ff <= '0;
         center_y_ff <= '0;
         normal_x_ff <= '0;
         normal_y_ff <= W'(64'd1 << FRAC_BITS);
         normal_z_ff <= '0;
         offset_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_FOCAL_X:      focal_x_ff  <= csr_wdata[W-2:0];
            REG_FOCAL_Y:      focal_y_ff  <= csr_wdata[W-2:0];
            REG_CENTER_X:     center_x_ff <= csr_wdata;
            REG_CENTER_Y:     center_y_ff <= csr_wdata;
            REG_NORMAL_X:     normal_x_ff <= csr_wdata;
            REG_NORMAL_Y:     normal_y_ff <= csr_wdata;
            REG_NORMAL_Z:     normal_z_ff <= csr_wdata;
            REG_PLANE_OFFSET: offset_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the whole pipeline unless a result is stuck at the output
   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   gpb_front #(.W(W), .F(FRAC_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_vld       (req_tvalid),
      .box_left     ($signed(req_tdata[W-1:0])),
      .box_top      ($signed(req_tdata[2*W-1:W])),
      .box_width    (req_tdata[3*W-2:2*W]),
      .box_height   (req_tdata[4*W-3:3*W-1]),
      .focal_x      (focal_x_ff),
      .focal_y      (focal_y_ff),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .normal_x     (normal_x_ff),
      .normal_y     (normal_y_ff),
      .normal_z     (normal_z_ff),
      .plane_offset (offset_ff),
      .out_vld      (f_vld),
      .den_mag      (f_den_mag),
      .den_neg      (f_den_neg),
      .num_mag      (f_num_mag),
      .num_neg      (f_num_neg),
      .err          (f_err)
   );

   for (genvar j = 0; j < 3; j++) begin : g_div
      gpb_div #(.W(W), .F(FRAC_BITS)) u_div (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .in_vld  (f_vld),
         .num_mag (f_num_mag[j]),
         .num_neg (f_num_neg[j]),
         .den_mag (f_den_mag),
         .den_neg (f_den_neg),
         .err_in  (f_err),
         .out_vld (d_vld[j]),
         .quot    (d_quot[j]),
         .err     (d_err[j])
      );
   end

   // Zero the point when any coordinate failed
   assign any_err    = |d_err;
   assign rsp_tvalid = d_vld[0];
   assign rsp_tdata  = OUT_W'({any_err,
                               any_err ? W'(0) : d_quot[2],
                               any_err ? W'(0) : d_quot[1],
                               any_err ? W'(0) : d_quot[0]});

   // Only the valid bit of the first divider drives the handshake
   logic unused_vld;
   assign unused_vld = ^d_vld[2:1] ^ ^req_tdata[IN_W-1:4*W-2];

endmodule
